@@ sv/c8alu_pkg.sv @@
// ----------------------------------------------------------------------------
// c8alu_pkg
// Shared types and constants for the 8-bit CPU arithmetic unit with flags.
// ----------------------------------------------------------------------------
`default_nettype none

package c8alu_pkg;

    // operation codes
    typedef enum logic [3:0] {
        OP_INC8   = 4'd0,
        OP_DEC8   = 4'd1,
        OP_RLCA   = 4'd2,
        OP_RLA    = 4'd3,
        OP_RRCA   = 4'd4,
        OP_RRA    = 4'd5,
        OP_DAA    = 4'd6,
        OP_SCF    = 4'd7,
        OP_ADD8   = 4'd8,
        OP_ADD16  = 4'd9,
        OP_ADDOFS = 4'd10,
        OP_INC16  = 4'd11,
        OP_DEC16  = 4'd12
    } c8alu_op_t;

    // decimal adjust corrections and limits
    localparam logic [7:0] DAA_LOW_FIX  = 8'h06;
    localparam logic [7:0] DAA_HIGH_FIX = 8'h60;
    localparam logic [7:0] DAA_HIGH_MAX = 8'h99;
    localparam logic [3:0] DAA_LOW_MAX  = 4'd9;

    // one operation transaction
    typedef struct packed {
        logic [3:0]  func;
        logic [15:0] operand_a;
        logic [15:0] operand_b;
        logic        zero_in;
        logic        subtract_in;
        logic        half_in;
        logic        carry_in;
    } c8alu_in_t;

    // one result transaction
    typedef struct packed {
        logic [15:0] result;
        logic        zero_out;
        logic        subtract_out;
        logic        half_out;
        logic        carry_out;
    } c8alu_out_t;

endpackage

`default_nettype wire

@@ sv/cpu8_alu_with_flags_unit.sv @@
// ----------------------------------------------------------------------------
// cpu8_alu_with_flags_unit
// 8-bit CPU arithmetic unit with zero, subtract, half carry and carry flags.
// ----------------------------------------------------------------------------
//
//  channel | valid     | stall     | payload
//  --------+-----------+-----------+----------------------------
//  op      | op_valid  | op_stall  | op_item  (c8alu_in_t)
//  res     | res_valid | res_stall | res_item (c8alu_out_t)
//
//  one transaction per cycle while res_stall is low; a transaction passes from the
//  operation register through the datapath into the result register.
//  reset clears both valid flags; payload registers are not reset.
//  res_stall holds the result register, and the operation register keeps
//  taking a new transaction until it too is full.
//
`default_nettype none

module cpu8_alu_with_flags_unit (
    input  wire  clk,
    input  wire  rst_n,
    input  wire  op_valid,
    output logic op_stall,
    input  wire  c8alu_pkg::c8alu_in_t  op_item,
    output logic res_valid,
    input  wire  res_stall,
    output c8alu_pkg::c8alu_out_t       res_item
);
    import c8alu_pkg::*;

    logic       op_valid_reg;
    c8alu_in_t  op_item_reg;
    logic       res_valid_reg;
    c8alu_out_t res_item_reg;
    c8alu_out_t res_item_next;
    logic       res_load;
    logic       op_load;

    // pipeline advance
    assign res_load = !res_valid_reg || !res_stall;
    assign op_load  = !op_valid_reg || res_load;
    assign op_stall = !op_load;

    // operation register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            op_valid_reg <= 1'b0;
        end
        else if (op_load)
        begin
            op_valid_reg <= op_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (op_load && op_valid)
        begin
            op_item_reg <= op_item;
        end
    end

    // datapath
    c8alu_core u_core (
        .op  (op_item_reg),
        .res (res_item_next)
    );

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (res_load)
        begin
            res_valid_reg <= op_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_load && op_valid_reg)
        begin
            res_item_reg <= res_item_next;
        end
    end

    assign res_valid = res_valid_reg;
    assign res_item  = res_item_reg;

endmodule

`default_nettype wire

@@ sv/c8alu_core.sv @@
// ----------------------------------------------------------------------------
// c8alu_core
// Combinational datapath: result and flags for one operation.
// ----------------------------------------------------------------------------
`default_nettype none

module c8alu_core (
    input  wire  c8alu_pkg::c8alu_in_t  op,
    output c8alu_pkg::c8alu_out_t       res
);
    import c8alu_pkg::*;

    logic [7:0]  a8;
    logic [7:0]  b8;
    logic [7:0]  inc8_sum;
    logic [7:0]  dec8_diff;
    logic [8:0]  add8_sum;
    logic [4:0]  add8_nib;
    logic [16:0] add16_sum;
    logic [12:0] add16_low;
    logic [15:0] ofs_sum;
    logic [15:0] inc16_sum;
    logic [15:0] dec16_diff;
    logic        daa_lo;
    logic        daa_hi;
    logic [7:0]  daa_fix;
    logic [7:0]  daa_val;

    // shared adders
    always_comb
    begin
        a8         = op.operand_a[7:0];
        b8         = op.operand_b[7:0];
        inc8_sum   = a8 + 8'd1;
        dec8_diff  = a8 - 8'd1;
        add8_sum   = {1'b0, a8} + {1'b0, b8};
        add8_nib   = {1'b0, a8[3:0]} + {1'b0, b8[3:0]};
        add16_sum  = {1'b0, op.operand_a} + {1'b0, op.operand_b};
        add16_low  = {1'b0, op.operand_a[11:0]} + {1'b0, op.operand_b[11:0]};
        ofs_sum    = op.operand_a + {{8{b8[7]}}, b8};
        inc16_sum  = op.operand_a + 16'd1;
        dec16_diff = op.operand_a - 16'd1;
    end

    // decimal adjust
    always_comb
    begin
        daa_lo  = op.half_in  | (!op.subtract_in && (a8[3:0] > DAA_LOW_MAX));
        daa_hi  = op.carry_in | (!op.subtract_in && (a8 > DAA_HIGH_MAX));
        daa_fix = (daa_lo ? DAA_LOW_FIX : 8'h00) | (daa_hi ? DAA_HIGH_FIX : 8'h00);
        daa_val = op.subtract_in ? (a8 - daa_fix) : (a8 + daa_fix);
    end

    // operation select; untouched flags pass through
    always_comb
    begin
        res.result       = op.operand_a;
        res.zero_out     = op.zero_in;
        res.subtract_out = op.subtract_in;
        res.half_out     = op.half_in;
        res.carry_out    = op.carry_in;
        unique case (op.func)
            OP_INC8:
            begin
                res.result       = {8'h00, inc8_sum};
                res.zero_out     = (inc8_sum == 8'h00);
                res.subtract_out = 1'b0;
                res.half_out     = (a8[3:0] == 4'hF);
            end
            OP_DEC8:
            begin
                res.result       = {8'h00, dec8_diff};
                res.zero_out     = (dec8_diff == 8'h00);
                res.subtract_out = 1'b1;
                res.half_out     = (a8[3:0] == 4'h0);
            end
            OP_RLCA:
            begin
                res.result       = {8'h00, a8[6:0], a8[7]};
                res.zero_out     = 1'b0;
                res.subtract_out = 1'b0;
                res.half_out     = 1'b0;
                res.carry_out    = a8[7];
            end
            OP_RLA:
            begin
                res.result       = {8'h00, a8[6:0], op.carry_in};
                res.zero_out     = 1'b0;
                res.subtract_out = 1'b0;
                res.half_out     = 1'b0;
                res.carry_out    = a8[7];
            end
            OP_RRCA:
            begin
                res.result       = {8'h00, a8[0], a8[7:1]};
                res.zero_out     = 1'b0;
                res.subtract_out = 1'b0;
                res.half_out     = 1'b0;
                res.carry_out    = a8[0];
            end
            OP_RRA:
            begin
                res.result       = {8'h00, op.carry_in, a8[7:1]};
                res.zero_out     = 1'b0;
                res.subtract_out = 1'b0;
                res.half_out     = 1'b0;
                res.carry_out    = a8[0];
            end
            OP_DAA:
            begin
                res.result    = {8'h00, daa_val};
                res.zero_out  = (daa_val == 8'h00);
                res.half_out  = 1'b0;
                res.carry_out = daa_hi;
            end
            OP_SCF:
            begin
                res.result       = {8'h00, a8};
                res.subtract_out = 1'b0;
                res.half_out     = 1'b0;
                res.carry_out    = 1'b1;
            end
            OP_ADD8:
            begin
                res.result       = {8'h00, add8_sum[7:0]};
                res.zero_out     = (add8_sum[7:0] == 8'h00);
                res.subtract_out = 1'b0;
                res.half_out     = add8_nib[4];
                res.carry_out    = add8_sum[8];
            end
            OP_ADD16:
            begin
                res.result       = add16_sum[15:0];
                res.subtract_out = 1'b0;
                res.half_out     = add16_low[12];
                res.carry_out    = add16_sum[16];
            end
            OP_ADDOFS:
            begin
                // carries come from the unsigned low-byte sum
                res.result       = ofs_sum;
                res.zero_out     = 1'b0;
                res.subtract_out = 1'b0;
                res.half_out     = add8_nib[4];
                res.carry_out    = add8_sum[8];
            end
            OP_INC16:
            begin
                res.result = inc16_sum;
            end
            OP_DEC16:
            begin
                res.result = dec16_diff;
            end
            default:
            begin
                res.result = op.operand_a;
            end
        endcase
    end

endmodule

`default_nettype wire

@@ sv/c8alu_checker.sv @@
// ----------------------------------------------------------------------------
// c8alu_checker
// Port-level checks on the arithmetic unit's handshakes and latency.
// ----------------------------------------------------------------------------
`default_nettype none

module c8alu_checker (
    input wire clk,
    input wire rst_n,
    input wire op_valid,
    input wire op_stall,
    input wire res_valid,
    input wire res_stall,
    input wire c8alu_pkg::c8alu_out_t res_item
);
    import c8alu_pkg::*;

    // a held result stays put
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_stall |=> res_valid && $stable(res_item))
        else $error("result changed while stalled");

    // input only backs up behind a stalled full result register
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        op_stall |-> res_valid && res_stall)
        else $error("input stalled without output back-pressure");

    // a new result follows an accepted transaction
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(res_valid) |-> $past(op_valid && !op_stall, 2))
        else $error("result appeared without an accepted transaction");

endmodule

bind cpu8_alu_with_flags_unit c8alu_checker u_c8alu_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .op_valid  (op_valid),
    .op_stall  (op_stall),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res_item  (res_item)
);

`default_nettype wire

@@ sim/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the 8-bit CPU arithmetic unit with flags. A queue of
// operations (a directed set, then random ones) feeds a clocked driver; a
// clocked monitor predicts each accepted operation and checks every result
// in order. Both sides insert random gaps and stalls.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import c8alu_pkg::*;

    localparam int          RANDOM_OPS     = 1350;
    localparam int          DRAIN_EVERY    = 450;
    localparam int          WATCHDOG_LIMIT = 2000;
    localparam int          TAIL_CYCLES    = 10;
    localparam logic [3:0]  SPARE_OP_FIRST = 4'd13;
    localparam logic [3:0]  SPARE_OP_LAST  = 4'd15;

    // pending operation; drain holds it back until all results are in
    typedef struct {
        c8alu_in_t op;
        bit        drain;
    } op_slot_t;

    logic       clk       = 1'b0;
    logic       rst_n     = 1'b0;
    logic       op_valid  = 1'b0;
    logic       op_stall;
    c8alu_in_t  op_item   = '0;
    logic       res_valid;
    logic       res_stall = 1'b0;
    c8alu_out_t res_item;

    op_slot_t   op_backlog[$];
    c8alu_out_t alu_results[$];

    bit         op_fire      = 1'b0;
    bit         res_fire     = 1'b0;
    bit         send_calm    = 1'b0;
    bit         recv_calm    = 1'b1;
    int         send_gap     = 0;
    int         stall_left   = 0;
    int         ops_taken    = 0;
    int         ops_total    = 0;
    int         idle_cycles  = 0;
    int         mismatches   = 0;

    cpu8_alu_with_flags_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .op_valid  (op_valid),
        .op_stall  (op_stall),
        .op_item   (op_item),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res_item  (res_item)
    );

    // clock, 8 ns period
    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    // expected result and flags for one operation
    function automatic c8alu_out_t alu_predict(input c8alu_in_t t);
        c8alu_out_t  o;
        logic [7:0]  a8;
        logic [7:0]  b8;
        logic [7:0]  r8;
        logic [7:0]  adj;
        logic [4:0]  sum5;
        logic [8:0]  sum9;
        logic [12:0] sum13;
        logic [16:0] sum17;
        logic        z;
        logic        n;
        logic        h;
        logic        c;
        a8 = t.operand_a[7:0];
        b8 = t.operand_b[7:0];
        z  = t.zero_in;
        n  = t.subtract_in;
        h  = t.half_in;
        c  = t.carry_in;
        o.result = t.operand_a;
        sum5  = {1'b0, a8[3:0]} + {1'b0, b8[3:0]};
        sum9  = {1'b0, a8} + {1'b0, b8};
        case (t.func)
            OP_INC8:
            begin
                r8 = a8 + 8'd1;
                h  = (a8[3:0] == 4'hF);
                z  = (r8 == 8'h00);
                n  = 1'b0;
                o.result = {8'h00, r8};
            end
            OP_DEC8:
            begin
                r8 = a8 - 8'd1;
                h  = (a8[3:0] == 4'h0);
                z  = (r8 == 8'h00);
                n  = 1'b1;
                o.result = {8'h00, r8};
            end
            OP_RLCA:
            begin
                o.result = {8'h00, a8[6:0], a8[7]};
                c = a8[7];
                z = 1'b0; n = 1'b0; h = 1'b0;
            end
            OP_RLA:
            begin
                o.result = {8'h00, a8[6:0], t.carry_in};
                c = a8[7];
                z = 1'b0; n = 1'b0; h = 1'b0;
            end
            OP_RRCA:
            begin
                o.result = {8'h00, a8[0], a8[7:1]};
                c = a8[0];
                z = 1'b0; n = 1'b0; h = 1'b0;
            end
            OP_RRA:
            begin
                o.result = {8'h00, t.carry_in, a8[7:1]};
                c = a8[0];
                z = 1'b0; n = 1'b0; h = 1'b0;
            end
            OP_DAA:
            begin
                // corrections decided from the incoming flags; carry only ever set
                adj = 8'h00;
                if (h || (!n && a8[3:0] > DAA_LOW_MAX))
                    adj = adj | DAA_LOW_FIX;
                if (c || (!n && a8 > DAA_HIGH_MAX))
                begin
                    adj = adj | DAA_HIGH_FIX;
                    c   = 1'b1;
                end
                r8 = n ? (a8 - adj) : (a8 + adj);
                z  = (r8 == 8'h00);
                h  = 1'b0;
                o.result = {8'h00, r8};
            end
            OP_SCF:
            begin
                o.result = {8'h00, a8};
                c = 1'b1; n = 1'b0; h = 1'b0;
            end
            OP_ADD8:
            begin
                h = sum5[4];
                c = sum9[8];
                z = (sum9[7:0] == 8'h00);
                n = 1'b0;
                o.result = {8'h00, sum9[7:0]};
            end
            OP_ADD16:
            begin
                sum13 = {1'b0, t.operand_a[11:0]} + {1'b0, t.operand_b[11:0]};
                sum17 = {1'b0, t.operand_a} + {1'b0, t.operand_b};
                h = sum13[12];
                c = sum17[16];
                n = 1'b0;
                o.result = sum17[15:0];
            end
            OP_ADDOFS:
            begin
                // carries come from the unsigned low-byte sum
                h = sum5[4];
                c = sum9[8];
                z = 1'b0; n = 1'b0;
                o.result = t.operand_a + {{8{b8[7]}}, b8};
            end
            OP_INC16:
                o.result = t.operand_a + 16'd1;
            OP_DEC16:
                o.result = t.operand_a - 16'd1;
            default:
                o.result = t.operand_a;
        endcase
        o.zero_out     = z;
        o.subtract_out = n;
        o.half_out     = h;
        o.carry_out    = c;
        return o;
    endfunction

    // idle length: mostly none, some short, a few long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        else if (r < 92)
            return $urandom_range(1, 3);
        else
            return $urandom_range(5, 30);
    endfunction

    // operand with a bias towards boundary values
    function automatic logic [15:0] pick_operand();
        logic [7:0] hi;
        hi = 8'($urandom);
        case ($urandom_range(0, 7))
            0: return 16'h0000;
            1: return 16'hFFFF;
            2: return {hi, 8'h0F};
            3: return {hi, 8'h80};
            4: return {hi, 8'h99};
            5: return {hi, 8'hFF};
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic add_op(input logic [3:0] func, input logic [15:0] a, input logic [15:0] b,
                          input logic [3:0] flags, input bit drain);
        op_slot_t s;
        s.op.func        = func;
        s.op.operand_a   = a;
        s.op.operand_b   = b;
        s.op.zero_in     = flags[3];
        s.op.subtract_in = flags[2];
        s.op.half_in     = flags[1];
        s.op.carry_in    = flags[0];
        s.drain          = drain;
        op_backlog.push_back(s);
    endtask

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("[%0t] mismatch: %s got %0h expected %0h", $realtime, what, got, want);
        mismatches++;
    endtask

    // operation driver, changes at the falling edge
    always @(negedge clk)
    begin : drive_ops
        logic      v;
        c8alu_in_t itm;
        op_slot_t  s;
        v   = op_valid;
        itm = op_item;
        if ($urandom_range(0, 299) == 0)
            send_calm = !send_calm;
        if (rst_n)
        begin
            if (op_fire)
                v = 1'b0;
            if (!v)
            begin
                if (send_gap > 0)
                    send_gap--;
                else if (op_backlog.size() > 0 &&
                         !(op_backlog[0].drain && alu_results.size() != 0))
                begin
                    s        = op_backlog.pop_front();
                    v        = 1'b1;
                    itm      = s.op;
                    send_gap = send_calm ? 0 : pick_gap();
                end
            end
        end
        op_valid <= v;
        op_item  <= itm;
    end

    // result stall, changes at the falling edge
    always @(negedge clk)
    begin : drive_stall
        logic s;
        s = 1'b0;
        if ($urandom_range(0, 249) == 0)
            recv_calm = !recv_calm;
        if (stall_left > 0)
        begin
            s = 1'b1;
            stall_left--;
        end
        else if (!recv_calm && $urandom_range(0, 2) == 0)
        begin
            stall_left = pick_gap();
            if (stall_left > 0)
            begin
                s = 1'b1;
                stall_left--;
            end
        end
        res_stall <= s;
    end

    // monitor: predict on accepted operations, check accepted results
    always @(posedge clk)
    begin : watch_ports
        c8alu_out_t want;
        op_fire  = rst_n && op_valid && !op_stall;
        res_fire = rst_n && res_valid && !res_stall;
        if (res_fire)
        begin
            if (alu_results.size() == 0)
                report_mismatch("result transaction with none outstanding", res_item.result, 0);
            else
            begin
                want = alu_results.pop_front();
                if (res_item.result !== want.result)
                    report_mismatch("result", res_item.result, want.result);
                if (res_item.zero_out !== want.zero_out)
                    report_mismatch("zero flag", res_item.zero_out, want.zero_out);
                if (res_item.subtract_out !== want.subtract_out)
                    report_mismatch("subtract flag", res_item.subtract_out, want.subtract_out);
                if (res_item.half_out !== want.half_out)
                    report_mismatch("half carry flag", res_item.half_out, want.half_out);
                if (res_item.carry_out !== want.carry_out)
                    report_mismatch("carry flag", res_item.carry_out, want.carry_out);
            end
        end
        if (op_fire)
        begin
            alu_results.push_back(alu_predict(op_item));
            ops_taken++;
        end
        // watchdog on cycles with no transaction on either side
        if (op_fire || res_fire)
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // stimulus and end of run
    initial
    begin : run_ops
        logic [3:0] f;
        // directed: boundaries of every operation
        add_op(OP_INC8,   16'h00FF, 16'h1234, 4'b0101, 1'b0);
        add_op(OP_INC8,   16'hAB0F, 16'hFFFF, 4'b1010, 1'b0);
        add_op(OP_DEC8,   16'h0001, 16'h0000, 4'b0011, 1'b0);
        add_op(OP_DEC8,   16'hFF00, 16'h0000, 4'b1000, 1'b0);
        add_op(OP_RLCA,   16'h5580, 16'h0000, 4'b1110, 1'b0);
        add_op(OP_RLA,    16'h0080, 16'h0000, 4'b1110, 1'b0);
        add_op(OP_RRCA,   16'h0001, 16'h0000, 4'b1110, 1'b0);
        add_op(OP_RRA,    16'hAA01, 16'h0000, 4'b0001, 1'b0);
        add_op(OP_DAA,    16'h009A, 16'h0000, 4'b0000, 1'b0);
        add_op(OP_DAA,    16'h0000, 16'h0000, 4'b0111, 1'b0);
        add_op(OP_DAA,    16'hFF45, 16'h0000, 4'b1001, 1'b0);
        add_op(OP_SCF,    16'hFFFF, 16'hFFFF, 4'b1110, 1'b0);
        add_op(OP_ADD8,   16'h00FF, 16'h0001, 4'b0100, 1'b0);
        add_op(OP_ADD8,   16'hFF0F, 16'hEE01, 4'b1011, 1'b0);
        add_op(OP_ADD8,   16'h0000, 16'h0000, 4'b0000, 1'b0);
        add_op(OP_ADD16,  16'hFFFF, 16'h0001, 4'b1000, 1'b0);
        add_op(OP_ADD16,  16'h0FFF, 16'h0001, 4'b0111, 1'b0);
        add_op(OP_ADDOFS, 16'h00FF, 16'h0001, 4'b1111, 1'b0);
        add_op(OP_ADDOFS, 16'h0000, 16'h00FF, 4'b1111, 1'b0);
        add_op(OP_ADDOFS, 16'h1234, 16'hFF80, 4'b0000, 1'b0);
        add_op(OP_INC16,  16'hFFFF, 16'h0000, 4'b1010, 1'b0);
        add_op(OP_DEC16,  16'h0000, 16'h0000, 4'b0101, 1'b0);
        // unused codes act as no operation
        for (int k = SPARE_OP_FIRST; k <= SPARE_OP_LAST; k++)
            add_op(k[3:0], 16'hC3A5, 16'h5A3C, 4'(k), 1'b0);

        // random, with a full drain of results now and then
        for (int i = 0; i < RANDOM_OPS; i++)
        begin
            if ($urandom_range(0, 19) == 0)
                f = 4'($urandom_range(SPARE_OP_FIRST, SPARE_OP_LAST));
            else
                f = 4'($urandom_range(OP_INC8, OP_DEC16));
            add_op(f, pick_operand(), pick_operand(), 4'($urandom_range(0, 15)),
                   (i % DRAIN_EVERY) == 0);
        end
        ops_total = op_backlog.size();

        // reset held low, then released at a falling edge
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        while (ops_taken != ops_total || alu_results.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        if (mismatches == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
